// ===== hdl/gregorian_date_arithmetic_core_defines.svh =====
// assertion macros shared by the rtl
`ifndef GREGORIAN_DATE_ARITHMETIC_CORE_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define GDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define GDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gda_pkg.sv =====
`default_nettype none

package gda_pkg;

  localparam int NumStages = 13;
  localparam int InW       = 48;
  localparam int OutW      = 80;

  // month numbers; feb, apr, jun, sep and nov have a length other than 31
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonJun = 4'd6;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonNov = 4'd11;
  localparam logic [3:0] MonDec = 4'd12;
  localparam logic [3:0] MonJan = 4'd1;

  localparam logic [14:0] YearBase   = 15'd4800;
  localparam logic [22:0] JdnOffset  = 23'd32045;
  localparam logic [22:0] WeekBase   = 23'd31741;
  localparam logic [22:0] Per400     = 23'd146097;
  localparam logic [17:0] Per100     = 18'd36524;
  localparam logic [15:0] Per4       = 16'd1461;
  localparam logic [10:0] LastQuad   = 11'd1460;
  localparam logic [10:0] DaysYear   = 11'd365;
  localparam logic [21:0] DistMax    = 22'h3FFFFF;

  // reciprocals: floor(x / c) = (x * k) >> s, exact for the operand widths used
  localparam int          DivHundredSh = 22;
  localparam logic [15:0] DivHundredK  = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
  localparam int          DivSevenSh   = 26;
  localparam logic [23:0] DivSevenK    = 24'(((64'd1 << 26) + 64'd6) / 64'd7);
  localparam int          DivPer400Sh  = 41;
  localparam logic [23:0] DivPer400K   = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
  localparam int          DivPer100Sh  = 34;
  localparam logic [18:0] DivPer100K   = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam int          DivPer4Sh    = 27;
  localparam logic [16:0] DivPer4K     = 17'(((64'd1 << 27) + 64'd1460) / 64'd1461);
  localparam int          DivWeekSh    = 12;
  localparam logic [9:0]  DivWeekK     = 10'(((64'd1 << 12) + 64'd6) / 64'd7);

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } jdn_en_t;

  typedef struct packed {
    logic        leap;
    logic [13:0] py;
    logic [3:0]  pm;
    logic [4:0]  pd;
    logic [13:0] ny;
    logic [3:0]  nm;
    logic [4:0]  nd;
  } date_res_t;

  // (153 * n + 2) / 5 with n the march-based month index
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    case (m)
      4'd0:    return 9'd275;
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      4'd3:    return 9'd0;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      4'd13:   return 9'd306;
      4'd14:   return 9'd337;
      default: return 9'd367;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      MonFeb:                         return leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: return 5'd30;
      default:                        return 5'd31;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gda_jdn.sv =====
`default_nettype none

module gda_jdn (
  input  wire logic            clk,
  input  wire gda_pkg::jdn_en_t en,
  input  wire logic [4:0]      day,
  input  wire logic [3:0]      month,
  input  wire logic [13:0]     year,
  output logic [22:0]          jdn
);

  logic [14:0] yy;
  logic [8:0]  mofs;
  logic [4:0]  dd;
  logic [7:0]  yyq;
  logic [22:0] js;
  logic [30:0] yyprod;

  // march-based year: january and february count with the year before
  always_ff @(posedge clk) begin
    if (en.s1) begin
      yy   <= 15'(year) + gda_pkg::YearBase - 15'(month <= gda_pkg::MonFeb);
      mofs <= gda_pkg::month_offset(month);
      dd   <= day;
    end
  end

  assign yyprod = 31'(yy) * 31'(gda_pkg::DivHundredK);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      yyq <= yyprod[29:gda_pkg::DivHundredSh];
      js  <= 23'(yy) * 23'(gda_pkg::DaysYear) + 23'(yy[14:2]) + 23'(mofs) + 23'(dd);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      jdn <= js - 23'(yyq) + 23'(yyq[7:2]) - gda_pkg::JdnOffset;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gregorian_date_arithmetic_core.sv =====
// Gregorian date arithmetic core.
// Input stream (s_axis_*): one word per request carrying a main date and a
// second date. Output stream (m_axis_*): one word per request with the next
// and previous date of the main date, its leap-year flag, a week number and
// the absolute day distance between the two dates (saturated to 22 bits).
// The datapath is a 13-stage pipeline: two julian day number units, then a
// chain of reciprocal multiplies for the / 7, mod 146097 / 36524 / 1461 steps
// of the week number. Throughput is one word per cycle while the receiver
// takes words, set by one pass through each stage.
// Each stage has its own valid bit and loads when it is empty or its
// successor loads, so bubbles close up and s_axis_tready stays high while
// any stage is free, also while a finished word waits at the output.
// When the receiver stalls, the output word holds and the pipe fills; after
// 13 accepted words s_axis_tready drops until the receiver takes one.
// rst (synchronous, active high) clears all valid bits; no word is in
// flight afterwards and no clearing pass is needed.
`default_nettype none

`include "gregorian_date_arithmetic_core_defines.svh"

module gregorian_date_arithmetic_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // day_of_month[4:0], month_number[8:5], year_number[22:9], other_day[27:23],
  // other_month[31:28], other_year[45:32], zero[47:46]
  input  wire logic [gda_pkg::InW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // following_day[4:0], next_month[8:5], next_year[22:9], prev_day[27:23],
  // prev_month[31:28], prev_year[45:32], leap_flag[46], week_of_year[52:47],
  // days_between[74:53], zero[79:75]
  output logic [gda_pkg::OutW-1:0]        m_axis_tdata
);

  localparam int N = gda_pkg::NumStages;

  logic [N:1] vld;
  logic [N:1] ld;

  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [13:0] year_number;
  logic [4:0]  other_day;
  logic [3:0]  other_month;
  logic [13:0] other_year;

  gda_pkg::jdn_en_t   jen;
  gda_pkg::date_res_t dres [3:N];
  gda_pkg::date_res_t dres_next;

  logic [22:0] j1;
  logic [22:0] j2;
  logic [21:0] days_apart [4:N];

  logic [4:0]  s1_d;
  logic [3:0]  s1_m;
  logic [13:0] s1_y;
  logic [7:0]  s1_yq;
  logic [29:0] yprod;
  logic [4:0]  s2_d;
  logic [3:0]  s2_m;
  logic [13:0] s2_y;
  logic        s2_leap;
  logic [13:0] yq_x100;
  logic        y100z;

  logic [20:0] q7;
  logic [46:0] p7;
  logic [22:0] jdiff;
  logic [22:0] w5;
  logic [22:0] w6;
  logic [5:0]  qa;
  logic [46:0] pa;
  logic [17:0] r1;
  logic [17:0] r1_8;
  logic [2:0]  qb;
  logic [36:0] pb;
  logic [15:0] r2;
  logic [15:0] r2_10;
  logic [4:0]  qc;
  logic [32:0] pc;
  logic [10:0] d4;
  logic [8:0]  d1;
  logic [8:0]  d1_next;
  logic [18:0] pw;
  logic [5:0]  week;

  assign day_of_month = s_axis_tdata[4:0];
  assign month_number = s_axis_tdata[8:5];
  assign year_number  = s_axis_tdata[22:9];
  assign other_day    = s_axis_tdata[27:23];
  assign other_month  = s_axis_tdata[31:28];
  assign other_year   = s_axis_tdata[45:32];

  // stage load enables: a stage takes a word when empty or when it passes one on
  assign ld[N] = !vld[N] || m_axis_tready;
  genvar gi;
  for (gi = 1; gi < N; gi++) begin : g_ld
    assign ld[gi] = !vld[gi] || ld[gi+1];
  end

  assign s_axis_tready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) vld[1] <= s_axis_tvalid;
      for (int i = 2; i <= N; i++) begin
        if (ld[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign jen.s1 = ld[1];
  assign jen.s2 = ld[2];
  assign jen.s3 = ld[3];

  gda_jdn u_jdn_main (
    .clk   (clk),
    .en    (jen),
    .day   (day_of_month),
    .month (month_number),
    .year  (year_number),
    .jdn   (j1)
  );

  gda_jdn u_jdn_other (
    .clk   (clk),
    .en    (jen),
    .day   (other_day),
    .month (other_month),
    .year  (other_year),
    .jdn   (j2)
  );

  // stage 1: year / 100 for the leap rule
  assign yprod = 30'(year_number) * 30'(gda_pkg::DivHundredK);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_d  <= day_of_month;
      s1_m  <= month_number;
      s1_y  <= year_number;
      s1_yq <= yprod[29:gda_pkg::DivHundredSh];
    end
  end

  // stage 2: leap flag
  assign yq_x100 = 14'(s1_yq) * 14'd100;
  assign y100z   = (s1_y == yq_x100);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_d    <= s1_d;
      s2_m    <= s1_m;
      s2_y    <= s1_y;
      s2_leap <= ((s1_y[1:0] == 2'd0) && !y100z) || (y100z && (s1_yq[1:0] == 2'd0));
    end
  end

  // stage 3: following and preceding dates
  always_comb begin
    logic [4:0] mlen;
    logic [4:0] plen;
    mlen = gda_pkg::month_len(s2_m, s2_leap);
    plen = gda_pkg::month_len(s2_m - 4'd1, s2_leap);
    dres_next.leap = s2_leap;
    if (s2_d >= mlen) begin
      dres_next.nd = 5'd1;
      if (s2_m >= gda_pkg::MonDec) begin
        dres_next.nm = gda_pkg::MonJan;
        dres_next.ny = s2_y + 14'd1;
      end else begin
        dres_next.nm = s2_m + 4'd1;
        dres_next.ny = s2_y;
      end
    end else begin
      dres_next.nd = s2_d + 5'd1;
      dres_next.nm = s2_m;
      dres_next.ny = s2_y;
    end
    if (s2_d <= 5'd1) begin
      if (s2_m <= gda_pkg::MonJan) begin
        dres_next.pd = 5'd31;
        dres_next.pm = gda_pkg::MonDec;
        dres_next.py = s2_y - 14'd1;
      end else begin
        dres_next.pd = plen;
        dres_next.pm = s2_m - 4'd1;
        dres_next.py = s2_y;
      end
    end else begin
      dres_next.pd = s2_d - 5'd1;
      dres_next.pm = s2_m;
      dres_next.py = s2_y;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) dres[3] <= dres_next;
    for (int i = 4; i <= N; i++) begin
      if (ld[i]) dres[i] <= dres[i-1];
    end
    // stage 4: saturated distance enters its delay line
    if (ld[4]) days_apart[4] <= jdiff[22] ? gda_pkg::DistMax : jdiff[21:0];
    for (int i = 5; i <= N; i++) begin
      if (ld[i]) days_apart[i] <= days_apart[i-1];
    end
  end

  // stage 4: distance and jdn / 7
  assign jdiff = (j1 > j2) ? (j1 - j2) : (j2 - j1);
  assign p7    = 47'(j1) * 47'(gda_pkg::DivSevenK);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      q7 <= p7[46:gda_pkg::DivSevenSh];
    end
  end

  // stage 5: jdn rounded down to a multiple of 7, shifted to the week origin
  always_ff @(posedge clk) begin
    if (ld[5]) w5 <= 23'(q7) * 23'd7 + gda_pkg::WeekBase;
  end

  // stages 6 to 11: mod 146097, mod 36524, mod 1461
  assign pa = 47'(w5) * 47'(gda_pkg::DivPer400K);
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      qa <= pa[46:gda_pkg::DivPer400Sh];
      w6 <= w5;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[7]) r1 <= 18'(w6 - 23'(qa) * gda_pkg::Per400);
  end

  assign pb = 37'(r1) * 37'(gda_pkg::DivPer100K);
  always_ff @(posedge clk) begin
    if (ld[8]) begin
      qb   <= pb[36:gda_pkg::DivPer100Sh];
      r1_8 <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[9]) r2 <= 16'(r1_8 - 18'(qb) * gda_pkg::Per100);
  end

  assign pc = 33'(r2) * 33'(gda_pkg::DivPer4K);
  always_ff @(posedge clk) begin
    if (ld[10]) begin
      qc    <= pc[31:gda_pkg::DivPer4Sh];
      r2_10 <= r2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[11]) d4 <= 11'(r2_10 - 16'(qc) * gda_pkg::Per4);
  end

  // stage 12: day within the year, the last day of a leap cycle kept as day 365
  always_comb begin
    logic        lq;
    logic [10:0] x;
    logic [10:0] m365;
    lq = (d4 >= gda_pkg::LastQuad);
    x  = d4 - 11'(lq);
    if (x >= 11'(3) * gda_pkg::DaysYear) begin
      m365 = x - 11'(3) * gda_pkg::DaysYear;
    end else if (x >= 11'(2) * gda_pkg::DaysYear) begin
      m365 = x - 11'(2) * gda_pkg::DaysYear;
    end else if (x >= gda_pkg::DaysYear) begin
      m365 = x - gda_pkg::DaysYear;
    end else begin
      m365 = x;
    end
    d1_next = 9'(m365) + 9'(lq);
  end

  always_ff @(posedge clk) begin
    if (ld[12]) d1 <= d1_next;
  end

  // stage 13: week = day / 7 + 1
  assign pw = 19'(d1) * 19'(gda_pkg::DivWeekK);
  always_ff @(posedge clk) begin
    if (ld[13]) week <= 6'(pw[18:gda_pkg::DivWeekSh]) + 6'd1;
  end

  assign m_axis_tvalid = vld[N];
  assign m_axis_tdata  = {5'd0, days_apart[N], week, dres[N].leap, dres[N].py, dres[N].pm,
                          dres[N].pd, dres[N].ny, dres[N].nm, dres[N].nd};

  `GDA_ASSERT_IMP(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready, "pipe stalled while empty")
  `GDA_ASSERT_NXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, vld[1], "accepted word lost")
  `GDA_ASSERT_IMP(a_week_range, m_axis_tvalid, week >= 6'd1 && week <= 6'd53, "week out of range")
  `GDA_ASSERT_IMP(a_days_nonzero, m_axis_tvalid, dres[N].nd != 5'd0 && dres[N].pd != 5'd0,
                  "zero day in result")

endmodule

`default_nettype wire
